// ===== src/cem_pkg.sv =====
// Shared types and constants for the control error metrics block.
package cem_pkg;

	// Fixed field widths
	localparam int BAND_W  = 13;
	localparam int ANGLE_W = 8;
	localparam int TIME_W  = 32;
	localparam int SHARE_W = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;

	// Share scale: hundredths of a percent
	localparam logic [SHARE_W-1:0] SHARE_SCALE = 14'd10000;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE_BAND      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ANGLE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SATURATION_DELTA = 2'd2;

	localparam logic [BAND_W-1:0]  BAND_RESET   = 13'd16;
	localparam logic [ANGLE_W-1:0] CENTER_RESET = 8'd90;
	localparam logic [ANGLE_W-1:0] DELTA_RESET  = 8'd45;

	// Input action codes
	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_SQR,
		ST_ACC,
		ST_SUM_GO,
		ST_SUM_WAIT,
		ST_SHR_GO,
		ST_SHR_WAIT,
		ST_DONE
	} cem_state_t;

	// Sequencer decodes
	typedef struct packed {
		logic in_take;
		logic err_load;
		logic sq_load;
		logic acc_load;
		logic num_load;
		logic div_start;
		logic div_shr;
		logic sqrt_start;
		logic out_load;
	} cem_ctrl_t;

endpackage

// ===== src/control_error_metrics_core.sv =====
// Top level: control loop error metrics with shared iterative divider and root unit.
// Throughput: one item at a time; in_stall is high until the result is handed to the output
//   register; for a record that follows the two passes through the shared divider (sum/count,
//   then share), while a clear skips the divider. in_stall also stays high while a result
//   waits on out_stall.
// Reset: arst_n clears all metrics and restores the registers to band 16, center 90, delta 45.
module control_error_metrics_core
	import cem_pkg::*;
#(
	parameter int DIST_BITS  = 13,
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	// sample input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  action,
	input  logic [DIST_BITS-1:0]  target_distance,
	input  logic [DIST_BITS-1:0]  measured_distance,
	input  logic [ANGLE_W-1:0]    servo_angle,
	input  logic [TIME_W-1:0]     time_ms,

	// metrics output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COUNT_BITS-1:0] sample_count,
	output logic [DIST_BITS-1:0]  rms_error,
	output logic [DIST_BITS-1:0]  max_abs_error,
	output logic [SHARE_W-1:0]    saturation_share,
	output logic                  is_settled,
	output logic [TIME_W-1:0]     settling_time
);

	// Derived widths
	localparam int SUM_W  = 2 * DIST_BITS + COUNT_BITS;
	// sum/count never exceeds 2^(2*DIST_BITS+1), even once the sample count saturates,
	// so the divider only has to produce that many quotient bits.
	localparam int LOW_W  = 2 * DIST_BITS + 1;
	localparam int IT_W   = $clog2(LOW_W + 1);
	localparam int RT_W   = DIST_BITS + 1;
	localparam int NUM_W  = COUNT_BITS + SHARE_W;
	localparam int CMP_W  = (DIST_BITS > BAND_W) ? DIST_BITS : BAND_W;

	// Configuration registers
	logic [BAND_W-1:0]  band_q;
	logic [ANGLE_W-1:0] center_q;
	logic [ANGLE_W-1:0] delta_q;

	// Captured transaction
	logic                 act_q;
	logic [DIST_BITS-1:0] tgt_q;
	logic [DIST_BITS-1:0] meas_q;
	logic [ANGLE_W-1:0]   ang_q;
	logic [TIME_W-1:0]    time_q;

	// Per-item intermediates
	logic [DIST_BITS-1:0]   err_q;
	logic                   sat_hit_q;
	logic [2*DIST_BITS-1:0] sq_q;
	logic [NUM_W-1:0]       num_q;

	// Metric state
	logic [SUM_W-1:0]      sum_q;
	logic [DIST_BITS-1:0]  largest_q;
	logic                  settled_q;
	logic [TIME_W-1:0]     settle_time_q;
	logic [COUNT_BITS-1:0] sat_cnt_q;
	logic [COUNT_BITS-1:0] cnt_q;

	// Output register
	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic [DIST_BITS-1:0]  out_rms_q;
	logic [DIST_BITS-1:0]  out_max_q;
	logic [SHARE_W-1:0]    out_share_q;
	logic                  out_settled_q;
	logic [TIME_W-1:0]     out_time_q;

	cem_state_t state_q, state_d;
	cem_ctrl_t  ctl;

	logic                  cnt_nz;
	logic                  div_busy;
	logic [LOW_W-1:0]      div_quo;
	logic [COUNT_BITS-1:0] div_rem_init;
	logic [LOW_W-1:0]      div_low_init;
	logic [IT_W-1:0]       div_iters;
	logic                  sqrt_busy;
	logic [RT_W-1:0]       sqrt_root;
	logic                  out_free;

	logic [DIST_BITS-1:0] err_d;
	logic [ANGLE_W-1:0]   dev_d;
	logic [SUM_W:0]       sum_add;

	assign cnt_nz   = (cnt_q != '0);
	assign out_free = !out_valid_q || !out_stall;

	// ------------------------------------------------------------------
	// Configuration: always ready and unchecked by the block, so the host must write only while the block idles
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q   <= BAND_RESET;
			center_q <= CENTER_RESET;
			delta_q  <= DELTA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STABLE_BAND:      band_q   <= cfg_data[BAND_W-1:0];
				CFG_CENTER_ANGLE:     center_q <= cfg_data[ANGLE_W-1:0];
				CFG_SATURATION_DELTA: delta_q  <= cfg_data[ANGLE_W-1:0];
				default: ;  // index beyond the register list is dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_ERR;
			ST_ERR:      state_d = ST_SQR;
			ST_SQR:      state_d = ST_ACC;
			ST_ACC:      state_d = ST_SUM_GO;
			ST_SUM_GO:   state_d = cnt_nz ? ST_SUM_WAIT : ST_DONE;
			ST_SUM_WAIT: if (!div_busy) state_d = ST_SHR_GO;
			ST_SHR_GO:   state_d = ST_SHR_WAIT;
			ST_SHR_WAIT: if (!div_busy && !sqrt_busy) state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE:   ctl.in_take = in_valid;
			ST_ERR:    ctl.err_load = 1'b1;
			ST_SQR:    ctl.sq_load = 1'b1;
			ST_ACC:    ctl.acc_load = 1'b1;
			ST_SUM_GO: begin
				ctl.num_load  = 1'b1;
				ctl.div_start = cnt_nz;
			end
			ST_SHR_GO: begin
				ctl.div_start  = 1'b1;
				ctl.div_shr    = 1'b1;
				ctl.sqrt_start = 1'b1;
			end
			ST_DONE:   ctl.out_load = out_free;
			default:   ctl = '0;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// ------------------------------------------------------------------
	// Capture and per-sample update
	// ------------------------------------------------------------------
	assign err_d = (tgt_q >= meas_q) ? (tgt_q - meas_q) : (meas_q - tgt_q);
	assign dev_d = (ang_q >= center_q) ? (ang_q - center_q) : (center_q - ang_q);
	assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(sq_q);

	always_ff @(posedge clk) begin
		if (ctl.in_take) begin
			act_q  <= action;
			tgt_q  <= target_distance;
			meas_q <= measured_distance;
			ang_q  <= servo_angle;
			time_q <= time_ms;
		end
		if (ctl.err_load) begin
			err_q     <= err_d;
			sat_hit_q <= (dev_d >= delta_q);
		end
		if (ctl.sq_load) begin
			sq_q <= (2 * DIST_BITS)'(err_q) * (2 * DIST_BITS)'(err_q);
		end
		// saturated count times 10000; registered before it feeds the divider
		if (ctl.num_load) begin
			num_q <= NUM_W'(sat_cnt_q) * NUM_W'(SHARE_SCALE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q         <= '0;
			largest_q     <= '0;
			settled_q     <= 1'b0;
			settle_time_q <= '0;
			sat_cnt_q     <= '0;
			cnt_q         <= '0;
		end else if (ctl.acc_load) begin
			if (act_q == ACT_CLEAR) begin
				sum_q         <= '0;
				largest_q     <= '0;
				settled_q     <= 1'b0;
				settle_time_q <= '0;
				sat_cnt_q     <= '0;
				cnt_q         <= '0;
			end else begin
				// saturating sum: carry out means past the all-ones limit
				sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
				if (err_q > largest_q) largest_q <= err_q;
				if (!settled_q && (CMP_W'(err_q) <= CMP_W'(band_q))) begin
					settled_q     <= 1'b1;
					settle_time_q <= time_q;
				end
				if (sat_hit_q && (sat_cnt_q != '1)) sat_cnt_q <= sat_cnt_q + COUNT_BITS'(1);
				if (cnt_q != '1) cnt_q <= cnt_q + COUNT_BITS'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Shared divider: first sum/count, then saturated*10000/count.
	// Remainder preloads with the dividend's upper bits, which are known to
	// be below the divisor, so only the live quotient bits are iterated.
	// ------------------------------------------------------------------
	always_comb begin
		if (ctl.div_shr) begin
			div_rem_init = num_q[NUM_W-1:SHARE_W];
			div_low_init = {num_q[SHARE_W-1:0], {(LOW_W - SHARE_W){1'b0}}};
			div_iters    = IT_W'(SHARE_W);
		end else begin
			div_rem_init = COUNT_BITS'(sum_q[SUM_W-1:LOW_W]);
			div_low_init = sum_q[LOW_W-1:0];
			div_iters    = IT_W'(LOW_W);
		end
	end

	cem_div #(
		.C_W   (COUNT_BITS),
		.LOW_W (LOW_W),
		.IT_W  (IT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.rem_init (div_rem_init),
		.low_init (div_low_init),
		.iters    (div_iters),
		.divisor  (cnt_q),
		.busy     (div_busy),
		.quo      (div_quo)
	);

	// Root of the mean square runs alongside the share division; it latches
	// the mean quotient at the same edge the divider restarts.
	cem_sqrt #(
		.RT_W (RT_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.sqrt_start),
		.radicand ({1'b0, div_quo}),
		.busy     (sqrt_busy),
		.root     (sqrt_root)
	);

	// ------------------------------------------------------------------
	// Output register: frees the sequencer while a result waits downstream
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_count_q   <= cnt_q;
			out_rms_q     <= cnt_nz ? sqrt_root[DIST_BITS-1:0] : '0;
			out_max_q     <= cnt_nz ? largest_q : '0;
			out_share_q   <= cnt_nz ? div_quo[SHARE_W-1:0] : '0;
			out_settled_q <= settled_q;
			out_time_q    <= settled_q ? settle_time_q : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign sample_count     = out_count_q;
	assign rms_error        = out_rms_q;
	assign max_abs_error    = out_max_q;
	assign saturation_share = out_share_q;
	assign is_settled       = out_settled_q;
	assign settling_time    = out_time_q;

endmodule

// ===== src/cem_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, preloaded remainder.
module cem_div
	import cem_pkg::*;
#(
	parameter int C_W   = 32,
	parameter int LOW_W = 27,
	parameter int IT_W  = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [C_W-1:0]   rem_init,
	input  logic [LOW_W-1:0] low_init,
	input  logic [IT_W-1:0]  iters,
	input  logic [C_W-1:0]   divisor,
	output logic             busy,
	output logic [LOW_W-1:0] quo
);

	logic             busy_q;
	logic [IT_W-1:0]  cnt_q;
	logic [C_W-1:0]   rem_q;
	logic [LOW_W-1:0] low_q;
	logic [LOW_W-1:0] quo_q;
	logic [C_W-1:0]   dvs_q;

	logic [C_W:0] trial;
	logic [C_W:0] diff;
	logic         ge;

	assign trial = {rem_q, low_q[LOW_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= (iters != '0);
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - IT_W'(1);
			busy_q <= (cnt_q != IT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			low_q <= low_init;
			quo_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[C_W-1:0] : trial[C_W-1:0];
			low_q <= {low_q[LOW_W-2:0], 1'b0};
			quo_q <= {quo_q[LOW_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// ===== src/cem_sqrt.sv =====
// Iterative integer square root, one root bit per cycle.
module cem_sqrt
	import cem_pkg::*;
#(
	parameter int RT_W = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2*RT_W-1:0] radicand,
	output logic              busy,
	output logic [RT_W-1:0]   root
);

	localparam int REM_W = RT_W + 2;
	localparam int CNT_W = $clog2(RT_W + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [2*RT_W-1:0] v_q;
	logic [REM_W-1:0]  rem_q;
	logic [RT_W-1:0]   root_q;

	logic [REM_W+1:0] rem2;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic             ge;

	assign rem2  = {rem_q, v_q[2*RT_W-1 -: 2]};
	assign trial = (REM_W + 2)'({root_q, 2'b01});
	assign ge    = rem2 >= trial;
	assign diff  = rem2 - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(RT_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[2*RT_W-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
			root_q <= {root_q[RT_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// ===== bench/cem_metrics_check.sv =====
// Checker for the control error metrics block: mirrors the metrics and compares every result.
module cem_metrics_check
	import cem_pkg::*;
#(
	parameter int DIST_BITS  = 13,
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  action,
	input  logic [DIST_BITS-1:0]  target_distance,
	input  logic [DIST_BITS-1:0]  measured_distance,
	input  logic [ANGLE_W-1:0]    servo_angle,
	input  logic [TIME_W-1:0]     time_ms,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [COUNT_BITS-1:0] sample_count,
	input  logic [DIST_BITS-1:0]  rms_error,
	input  logic [DIST_BITS-1:0]  max_abs_error,
	input  logic [SHARE_W-1:0]    saturation_share,
	input  logic                  is_settled,
	input  logic [TIME_W-1:0]     settling_time,
	output int                    mismatch_count,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SUM_W = 2 * DIST_BITS + COUNT_BITS;

	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic [DIST_BITS-1:0]  rms;
		logic [DIST_BITS-1:0]  peak;
		logic [SHARE_W-1:0]    share;
		logic                  settled;
		logic [TIME_W-1:0]     settle_ms;
	} metrics_t;

	metrics_t metrics_q[$];

	logic [BAND_W-1:0]     band_reg;
	logic [ANGLE_W-1:0]    center_reg;
	logic [ANGLE_W-1:0]    delta_reg;

	logic [SUM_W-1:0]      err_sq_sum;
	logic [DIST_BITS-1:0]  peak_err;
	logic                  settled;
	logic [TIME_W-1:0]     settle_ms;
	logic [COUNT_BITS-1:0] sat_count;
	logic [COUNT_BITS-1:0] rec_count;
	int                    n_checked;

	function automatic logic [63:0] floor_root(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] trial;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= v)
				r = trial;
		end
		return r;
	endfunction

	function automatic void clear_stats();
		err_sq_sum = '0;
		peak_err   = '0;
		settled    = 1'b0;
		settle_ms  = '0;
		sat_count  = '0;
		rec_count  = '0;
	endfunction

	// Advance the mirrored loop statistics by one transaction, return the metrics after it
	function automatic metrics_t step_metrics(logic act, logic [DIST_BITS-1:0] tgt,
			logic [DIST_BITS-1:0] meas, logic [ANGLE_W-1:0] ang, logic [TIME_W-1:0] stamp);
		logic [DIST_BITS-1:0] err;
		logic [SUM_W:0]       sq;
		logic [SUM_W:0]       wide_sum;
		logic [ANGLE_W-1:0]   dev;
		metrics_t             m;
		if (act == ACT_CLEAR) begin
			clear_stats();
		end else begin
			err = (tgt >= meas) ? tgt - meas : meas - tgt;
			sq = err;
			sq = sq * sq;
			wide_sum = {1'b0, err_sq_sum} + sq;
			err_sq_sum = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
			if (err > peak_err)
				peak_err = err;
			if (!settled && err <= band_reg) begin
				settled = 1'b1;
				settle_ms = stamp;
			end
			dev = (ang >= center_reg) ? ang - center_reg : center_reg - ang;
			if (dev >= delta_reg && sat_count != '1)
				sat_count++;
			if (rec_count != '1)
				rec_count++;
		end
		m.count = rec_count;
		if (rec_count != 0) begin
			m.rms   = DIST_BITS'(floor_root(64'(err_sq_sum) / 64'(rec_count)));
			m.peak  = peak_err;
			m.share = SHARE_W'((64'(sat_count) * 64'(SHARE_SCALE)) / 64'(rec_count));
		end else begin
			m.rms   = '0;
			m.peak  = '0;
			m.share = '0;
		end
		m.settled   = settled;
		m.settle_ms = settled ? settle_ms : '0;
		return m;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("[%0t] result %0d %s: got 0x%0h, expected 0x%0h",
			$time, n_checked, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		metrics_t want;
		if (!arst_n) begin
			band_reg   = BAND_RESET;
			center_reg = CENTER_RESET;
			delta_reg  = DELTA_RESET;
			clear_stats();
			metrics_q.delete();
			n_checked = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_STABLE_BAND:      band_reg   = cfg_data[BAND_W-1:0];
					CFG_CENTER_ANGLE:     center_reg = cfg_data[ANGLE_W-1:0];
					CFG_SATURATION_DELTA: delta_reg  = cfg_data[ANGLE_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (metrics_q.size() == 0) begin
					report_mismatch("unexpected result, sample_count", sample_count, 0);
				end else begin
					want = metrics_q.pop_front();
					if (sample_count !== want.count)
						report_mismatch("sample_count", sample_count, want.count);
					if (rms_error !== want.rms)
						report_mismatch("rms_error", rms_error, want.rms);
					if (max_abs_error !== want.peak)
						report_mismatch("max_abs_error", max_abs_error, want.peak);
					if (saturation_share !== want.share)
						report_mismatch("saturation_share", saturation_share, want.share);
					if (is_settled !== want.settled)
						report_mismatch("is_settled", is_settled, want.settled);
					if (settling_time !== want.settle_ms)
						report_mismatch("settling_time", settling_time, want.settle_ms);
				end
				n_checked++;
			end
			if (in_valid && !in_stall)
				metrics_q.push_back(step_metrics(action, target_distance, measured_distance,
					servo_angle, time_ms));
			outstanding <= metrics_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the control error metrics block: stimulus, handshake pressure and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cem_pkg::*;

	localparam int DIST_BITS       = 13;
	localparam int COUNT_BITS      = 32;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int HOLD_CYCLES     = 400;        // long output hold, far beyond one result's latency
	localparam int DRAIN_CYCLES    = 60;
	localparam int N_PHASES        = 8;
	localparam int ITEMS_PER_PHASE = 240;
	localparam int MAX_GAP         = 24;

	// Index 3 decodes to no register; writes there must leave everything alone
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [DIST_BITS-1:0] DIST_MAX  = '1;

	typedef struct {
		logic                 action;
		logic [DIST_BITS-1:0] tgt;
		logic [DIST_BITS-1:0] meas;
		logic [ANGLE_W-1:0]   ang;
		logic [TIME_W-1:0]    stamp;
	} sample_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  action;
	logic [DIST_BITS-1:0]  target_distance;
	logic [DIST_BITS-1:0]  measured_distance;
	logic [ANGLE_W-1:0]    servo_angle;
	logic [TIME_W-1:0]     time_ms;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [COUNT_BITS-1:0] sample_count;
	logic [DIST_BITS-1:0]  rms_error;
	logic [DIST_BITS-1:0]  max_abs_error;
	logic [SHARE_W-1:0]    saturation_share;
	logic                  is_settled;
	logic [TIME_W-1:0]     settling_time;

	int                    fail_count;
	int                    pending;       // results still owed by the block, as seen by the checker
	int                    cycle_count = 0;
	int                    send_idle_pct = 0;
	int                    stall_pct = 0;
	int                    hold_requests = 0;
	int                    hold_seen = 0;
	int                    hold_left = 0;
	int                    n_records = 0;
	int                    n_clears = 0;
	int                    n_settings = 0;
	logic [TIME_W-1:0]     time_base = '0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	control_error_metrics_core #(
		.DIST_BITS  (DIST_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.action            (action),
		.target_distance   (target_distance),
		.measured_distance (measured_distance),
		.servo_angle       (servo_angle),
		.time_ms           (time_ms),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.sample_count      (sample_count),
		.rms_error         (rms_error),
		.max_abs_error     (max_abs_error),
		.saturation_share  (saturation_share),
		.is_settled        (is_settled),
		.settling_time     (settling_time)
	);

	cem_metrics_check #(
		.DIST_BITS  (DIST_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_metrics_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.action            (action),
		.target_distance   (target_distance),
		.measured_distance (measured_distance),
		.servo_angle       (servo_angle),
		.time_ms           (time_ms),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.sample_count      (sample_count),
		.rms_error         (rms_error),
		.max_abs_error     (max_abs_error),
		.saturation_share  (saturation_share),
		.is_settled        (is_settled),
		.settling_time     (settling_time),
		.mismatch_count    (fail_count),
		.outstanding       (pending)
	);

	// Output side. A long hold is requested by bumping hold_requests; this process
	// owns the countdown, so the top keeps offering transactions while the result
	// register stays full and the block backs up into its input.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still owed", cycle_count, pending);
			$display("Mismatches found");
			$finish;
		end
	end

	// Config writes stay asserted across back-to-back calls; the caller drops cfg_valid
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_registers(int band, int center, int delta);
		cfg_write(CFG_STABLE_BAND, CFG_DATA_W'(band));
		cfg_write(CFG_CENTER_ANGLE, CFG_DATA_W'(center));
		cfg_write(CFG_SATURATION_DELTA, CFG_DATA_W'(delta));
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// One input transaction. With no gap, valid stays high from the previous one,
	// so valid is never dropped and raised within one time step.
	task automatic send_sample(sample_t s);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid          <= 1'b1;
		action            <= s.action;
		target_distance   <= s.tgt;
		measured_distance <= s.meas;
		servo_angle       <= s.ang;
		time_ms           <= s.stamp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (s.action == ACT_CLEAR)
			n_clears++;
		else
			n_records++;
	endtask

	// Stop offering and wait until the block owes nothing; registers are safe to write after
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic sample_t record_item(int tgt, int meas, int ang, logic [TIME_W-1:0] stamp);
		sample_t s;
		s.action = ACT_RECORD;
		s.tgt    = DIST_BITS'(tgt);
		s.meas   = DIST_BITS'(meas);
		s.ang    = ANGLE_W'(ang);
		s.stamp  = stamp;
		return s;
	endfunction

	// Payload of a clear is don't-care, so fill it with noise
	function automatic sample_t clear_item();
		sample_t s;
		s.action = ACT_CLEAR;
		s.tgt    = DIST_BITS'($urandom_range(DIST_MAX));
		s.meas   = DIST_BITS'($urandom_range(DIST_MAX));
		s.ang    = ANGLE_W'($urandom_range(255));
		s.stamp  = $urandom();
		return s;
	endfunction

	// Records, half of them near the setpoint (so the band check flips both ways), the rest
	// with full-range errors; rare clears, occasional out-of-range angles.
	function automatic sample_t random_sample();
		sample_t s;
		int m;
		if ($urandom_range(99) < 4)
			return clear_item();
		s.action = ACT_RECORD;
		s.tgt = DIST_BITS'($urandom_range(DIST_MAX));
		if ($urandom_range(3) < 2) begin
			m = int'(s.tgt) + int'($urandom_range(96)) - 48;
			if (m < 0)
				m = 0;
			if (m > int'(DIST_MAX))
				m = int'(DIST_MAX);
			s.meas = DIST_BITS'(m);
		end else begin
			s.meas = DIST_BITS'($urandom_range(DIST_MAX));
		end
		s.ang = ($urandom_range(9) == 0) ? ANGLE_W'($urandom_range(255))
			: ANGLE_W'($urandom_range(180));
		if ($urandom_range(3) == 0) begin
			s.stamp = $urandom();
		end else begin
			time_base = time_base + $urandom_range(40, 1);
			s.stamp = time_base;
		end
		return s;
	endfunction

	// Register setting per phase: reset values, all-zero, upper extremes, then random
	task automatic program_phase(int p);
		case (p)
			0: set_registers(int'(BAND_RESET), int'(CENTER_RESET), int'(DELTA_RESET));
			1: set_registers(0, 0, 0);
			2: set_registers(int'(DIST_MAX), 180, 180);
			default: set_registers($urandom_range(1) ? int'($urandom_range(64))
				: int'($urandom_range(DIST_MAX)), int'($urandom_range(180)),
				int'($urandom_range(90)));
		endcase
	endtask

	// Handshake mix per phase: none, sender gaps, receiver stalls, both
	task automatic set_idle_mix(int p);
		case (p % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct <= 0;
			end
			1: begin
				send_idle_pct = 45;
				stall_pct <= 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct <= 45;
			end
			default: begin
				send_idle_pct = 31;
				stall_pct <= 31;
			end
		endcase
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg_valid         <= 1'b0;
		cfg_index         <= CFG_STABLE_BAND;
		cfg_data          <= '0;
		in_valid          <= 1'b0;
		action            <= ACT_RECORD;
		target_distance   <= '0;
		measured_distance <= '0;
		servo_angle       <= '0;
		time_ms           <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset register values (band 16, center 90, delta 45)
		send_sample(clear_item());                                // clear with nothing recorded
		send_sample(record_item(8191, 0, 180, 1));                // largest error, full deviation
		send_sample(record_item(0, 8191, 0, 2));                  // same error, other sign
		send_sample(record_item(100, 116, 135, 32'hFFFF_FFFF));   // error on band edge settles
		send_sample(record_item(116, 100, 134, 5));               // already settled, time holds
		send_sample(record_item(2000, 2000, 46, 6));              // deviation just below delta
		send_sample(clear_item());                                // everything back to zero
		send_sample(record_item(50, 67, 90, 7));                  // one past band: unsettled
		send_sample(record_item(300, 300, 45, 0));                // settles with time zero
		send_sample(record_item(8191, 8191, 255, 32'h8000_0000)); // angle beyond 180
		send_sample(record_item(1, 0, 200, 9));
		wait_idle();

		// Zero band, center and delta: every sample saturates, only exact hits settle.
		// A write to the spare index goes first and must change nothing.
		cfg_write(CFG_SPARE, '1);
		set_registers(0, 0, 0);
		send_sample(clear_item());
		send_sample(record_item(10, 11, 0, 20));
		send_sample(record_item(10, 10, 255, 21));
		wait_idle();

		// Widest band; center written with junk above bit 7 (low byte is 180)
		set_registers(int'(DIST_MAX), 'h1FB4, 180);
		send_sample(record_item(0, 8191, 0, 30));
		send_sample(record_item(0, 0, 1, 31));
		wait_idle();

		// Out-of-range center and delta, compared as plain unsigned values
		set_registers(5, 255, 255);
		send_sample(record_item(7, 0, 0, 40));
		send_sample(record_item(0, 7, 200, 41));
		wait_idle();

		// Random phases; each starts idle with a fresh register setting
		for (int p = 0; p < N_PHASES; p++) begin
			program_phase(p);
			set_idle_mix(p);
			repeat (ITEMS_PER_PHASE)
				send_sample(random_sample());
			wait_idle();

			// Back-pressure burst: output held off while the sender keeps pushing
			if (p == 3) begin
				send_idle_pct = 0;
				stall_pct <= 0;
				hold_requests <= hold_requests + 1;
				repeat (12)
					send_sample(random_sample());
				wait_idle();
			end
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		$display("Covered %0d records and %0d clears under %0d register settings,",
			n_records, n_clears, n_settings);
		$display("with sender gaps, output stalls and one %0d-cycle output hold.", HOLD_CYCLES);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== control_error_metrics_core.f =====
src/cem_pkg.sv
src/cem_div.sv
src/cem_sqrt.sv
src/control_error_metrics_core.sv
bench/cem_metrics_check.sv
bench/tb_top.sv
